@@ hw/rtl/sdt_pkg.sv @@
package sdt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DESC_W      = 64;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] seg_base;
        logic [19:0] seg_limit;
        logic [15:0] seg_flags;
    } t_req;

    typedef struct packed {
        logic [63:0] descriptor_word;
        logic [5:0]  entry_index;
        logic        found;
        logic [6:0]  entry_count;
        logic [1:0]  status;
    } t_rsp;

    // Flag bits 11:8 have no place in the descriptor and are dropped.
    function automatic logic [DESC_W-1:0] pack_descriptor(input t_req req);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = {req.seg_base[31:24], req.seg_flags[15:12], req.seg_limit[19:16],
              req.seg_flags[7:0], req.seg_base[23:16]};
        lo = {req.seg_base[15:0], req.seg_limit[15:0]};
        return {hi, lo};
    endfunction

endpackage

@@ hw/rtl/sdt_ram.sv @@
module sdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/segment_descriptor_table.sv @@
// Segment descriptor table. A beat is taken when start is high and busy is low; each
// beat packs base, limit and flags into a 64-bit descriptor and appends it, searches
// for it, or removes it (an unused command only answers). The result appears on o_rsp
// for exactly one cycle with o_valid high, and the receiver cannot stall it. Append, a
// full table and an unused command answer in the cycle after the beat. Search walks the
// stored entries through the single read port of the table RAM, one entry per cycle
// (an empty table answers in the cycle after the beat). Remove adds the shift of the
// later entries, again one entry per cycle through that port. The table needs no
// clearing after reset.
module segment_descriptor_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sdt_pkg::t_req i_req,
    output logic          o_valid,
    output sdt_pkg::t_rsp o_rsp
);
    import sdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_cmp, n_cmp;
    logic                r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]    r_hit, n_hit;
    logic                r_is_rm, n_is_rm;
    logic [DESC_W-1:0]   r_word, n_word;
    logic                r_valid, n_valid;
    t_rsp                r_rsp, n_rsp;

    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [DESC_W-1:0]   wdata;
    logic [IDX_W-1:0]    raddr;
    logic [DESC_W-1:0]   rdata;
    logic [DESC_W-1:0]   req_word;
    logic                match;

    assign req_word = pack_descriptor(i_req);
    assign match    = r_cmp_vld && (rdata == r_word);

    sdt_ram #(
        .WIDTH (DESC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_rd      = r_rd;
        n_cmp     = r_cmp;
        n_cmp_vld = r_cmp_vld;
        n_hit     = r_hit;
        n_is_rm   = r_is_rm;
        n_word    = r_word;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        we        = 1'b0;
        waddr     = r_cnt[IDX_W-1:0];
        wdata     = req_word;
        raddr     = r_rd[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_word                = req_word;
                    n_rsp.descriptor_word = req_word;
                    n_rsp.entry_index     = '0;
                    n_rsp.found           = 1'b0;
                    n_rsp.entry_count     = 7'(r_cnt);
                    n_rsp.status          = ST_OK;
                    case (i_req.cmd)
                        CMD_APPEND: begin
                            n_valid = 1'b1;
                            if (r_cnt == CNT_W'(TABLE_DEPTH)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                we                = 1'b1;
                                n_cnt             = r_cnt + CNT_W'(1);
                                n_rsp.entry_index = 6'(r_cnt);
                                n_rsp.entry_count = 7'(r_cnt + CNT_W'(1));
                            end
                        end
                        CMD_SEARCH, CMD_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_valid      = 1'b1;
                                n_rsp.status = ST_MISS;
                            end else begin
                                n_state   = S_SCAN;
                                n_rd      = '0;
                                n_cmp_vld = 1'b0;
                                n_is_rm   = (i_req.cmd == CMD_REMOVE);
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Reads are issued one ahead; the compare sees the entry read last cycle.
                n_cmp_vld = (r_rd < r_cnt);
                n_cmp     = r_rd;
                if (r_rd < r_cnt) begin
                    n_rd = r_rd + CNT_W'(1);
                end
                if (match) begin
                    if (r_is_rm) begin
                        n_state   = S_SHIFT;
                        n_hit     = r_cmp;
                        n_rd      = r_cmp + CNT_W'(1);
                        n_cmp_vld = 1'b0;
                    end else begin
                        n_state               = S_IDLE;
                        n_valid               = 1'b1;
                        n_rsp.descriptor_word = r_word;
                        n_rsp.entry_index     = 6'(r_cmp);
                        n_rsp.found           = 1'b1;
                        n_rsp.entry_count     = 7'(r_cnt);
                        n_rsp.status          = ST_OK;
                    end
                end else if (r_cmp_vld && (r_cmp + CNT_W'(1) == r_cnt)) begin
                    n_state               = S_IDLE;
                    n_valid               = 1'b1;
                    n_rsp.descriptor_word = r_word;
                    n_rsp.entry_index     = '0;
                    n_rsp.found           = 1'b0;
                    n_rsp.entry_count     = 7'(r_cnt);
                    n_rsp.status          = ST_MISS;
                end
            end

            S_SHIFT: begin
                // Each entry read from slot k is written back one slot lower.
                n_cmp_vld = (r_rd < r_cnt);
                n_cmp     = r_rd;
                if (r_rd < r_cnt) begin
                    n_rd = r_rd + CNT_W'(1);
                end
                if (r_cmp_vld) begin
                    we    = 1'b1;
                    waddr = IDX_W'(r_cmp - CNT_W'(1));
                    wdata = rdata;
                end else if (r_rd >= r_cnt) begin
                    n_state               = S_IDLE;
                    n_cnt                 = r_cnt - CNT_W'(1);
                    n_valid               = 1'b1;
                    n_rsp.descriptor_word = r_word;
                    n_rsp.entry_index     = 6'(r_hit);
                    n_rsp.found           = 1'b1;
                    n_rsp.entry_count     = 7'(r_cnt - CNT_W'(1));
                    n_rsp.status          = ST_OK;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_cmp_vld <= n_cmp_vld;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd    <= n_rd;
        r_cmp   <= n_cmp;
        r_hit   <= n_hit;
        r_is_rm <= n_is_rm;
        r_word  <= n_word;
        r_rsp   <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

@@ hw/rtl/sdt_chk.sv @@
module sdt_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input sdt_pkg::t_req i_req,
    input logic          o_valid,
    input sdt_pkg::t_rsp o_rsp
);
    import sdt_pkg::*;

    // Append and unused commands answer in the cycle after the beat.
    a_append_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.cmd == CMD_APPEND || i_req.cmd == CMD_UNUSED) |=> o_valid)
        else $error("append beat did not answer in the next cycle");

    // The block only goes busy after it took a beat.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted beat");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.found |-> o_rsp.status == ST_OK)
        else $error("found result carries an error status");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status == ST_MISS |-> !o_rsp.found && o_rsp.entry_index == '0)
        else $error("miss result carries an index or found flag");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status == ST_FULL |-> o_rsp.entry_count == 7'(TABLE_DEPTH))
        else $error("full status reported with a table that is not full");

endmodule

bind segment_descriptor_table sdt_chk u_sdt_chk (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sdt_pkg::*;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_req  i_req   = '0;
    logic  o_valid;
    t_rsp  o_rsp;

    // Descriptors currently held in the table, kept dense like the block's store.
    logic [63:0] table_words[$];
    t_rsp        pending_rsps[$];
    int          n_fail       = 0;
    int          gap_pct      = 0;

    segment_descriptor_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #15_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic [63:0] encode_descriptor(input t_req req);
        logic [63:0] w;
        w            = '0;
        w[15:0]      = req.seg_limit[15:0];
        w[31:16]     = req.seg_base[15:0];
        w[39:32]     = req.seg_base[23:16];
        w[47:40]     = req.seg_flags[7:0];
        w[51:48]     = req.seg_limit[19:16];
        w[55:52]     = req.seg_flags[15:12];
        w[63:56]     = req.seg_base[31:24];
        return w;
    endfunction

    // Rebuilds a request that packs to the given word; the unused flag
    // nibble is random, so hits also cover aliased flag words.
    function automatic t_req req_for_word(input logic [1:0] cmd, input logic [63:0] w);
        t_req r;
        r.cmd       = cmd;
        r.seg_base  = {w[63:56], w[39:32], w[31:16]};
        r.seg_limit = {w[51:48], w[15:0]};
        r.seg_flags = {w[55:52], 4'($urandom), w[47:40]};
        return r;
    endfunction

    function automatic t_req make_req(input logic [1:0] cmd, input logic [31:0] base,
                                      input logic [19:0] lim, input logic [15:0] flags);
        t_req r;
        r.cmd       = cmd;
        r.seg_base  = base;
        r.seg_limit = lim;
        r.seg_flags = flags;
        return r;
    endfunction

    function automatic t_rsp apply_table_op(input t_req req);
        t_rsp        rsp;
        logic [63:0] w;
        int          hit;
        w                   = encode_descriptor(req);
        rsp                 = '0;
        rsp.descriptor_word = w;
        rsp.status          = ST_OK;
        hit                 = -1;
        case (req.cmd)
            CMD_APPEND: begin
                if (table_words.size() >= TABLE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    rsp.entry_index = 6'(table_words.size());
                    table_words.push_back(w);
                end
            end
            CMD_SEARCH, CMD_REMOVE: begin
                for (int i = 0; i < table_words.size() && hit < 0; i++) begin
                    if (table_words[i] == w) hit = i;
                end
                if (hit < 0) begin
                    rsp.status = ST_MISS;
                end else begin
                    rsp.entry_index = 6'(hit);
                    rsp.found       = 1'b1;
                    if (req.cmd == CMD_REMOVE) table_words.delete(hit);
                end
            end
            default: begin
            end
        endcase
        rsp.entry_count = 7'(table_words.size());
        return rsp;
    endfunction

    function automatic t_req random_req(input int append_pct);
        t_req r;
        int   sel;
        r.seg_base  = $urandom();
        r.seg_limit = 20'($urandom());
        r.seg_flags = 16'($urandom());
        // A narrow value range makes random words collide now and then.
        if ($urandom_range(0, 99) < 20) begin
            r.seg_base  = $urandom_range(0, 3);
            r.seg_limit = 20'($urandom_range(0, 3));
            r.seg_flags = 16'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 99) < append_pct) begin
            r.cmd = CMD_APPEND;
        end else begin
            sel   = $urandom_range(0, 99);
            r.cmd = (sel < 48) ? CMD_SEARCH : (sel < 96) ? CMD_REMOVE : CMD_UNUSED;
        end
        if (table_words.size() > 0 && r.cmd != CMD_UNUSED &&
            $urandom_range(0, 99) < ((r.cmd == CMD_APPEND) ? 20 : 75)) begin
            r = req_for_word(r.cmd,
                             table_words[$urandom_range(0, table_words.size() - 1)]);
        end
        return r;
    endfunction

    // Drives one beat and holds it until the block takes it; start stays high
    // on return so that a following beat can go out back to back.
    task automatic send_req(input t_req req);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_rsps.push_back(apply_table_op(req));
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_rsps.size() == 0) begin
                $error("result beat with no request outstanding");
                n_fail++;
            end else begin
                want = pending_rsps.pop_front();
                if (o_rsp.descriptor_word !== want.descriptor_word) begin
                    $error("descriptor_word: expected %h, actual %h",
                           want.descriptor_word, o_rsp.descriptor_word);
                    n_fail++;
                end
                if (o_rsp.entry_index !== want.entry_index) begin
                    $error("entry_index: expected %0d, actual %0d",
                           want.entry_index, o_rsp.entry_index);
                    n_fail++;
                end
                if (o_rsp.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_rsp.found);
                    n_fail++;
                end
                if (o_rsp.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, o_rsp.entry_count);
                    n_fail++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_rsp.status);
                    n_fail++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_req(make_req(CMD_SEARCH, 32'h0, 20'h0, 16'h0));
        send_req(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hFFFF));
        send_req(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hFFFF));
    endtask

    task automatic test_basic_ops();
        send_req(make_req(CMD_APPEND, 32'h0, 20'h0, 16'h0));
        send_req(make_req(CMD_APPEND, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hFFFF));
        // Flag bits 11:8 are dropped, so this packs to the same word as entry 0.
        send_req(make_req(CMD_APPEND, 32'h0, 20'h0, 16'h0F00));
        send_req(make_req(CMD_APPEND, 32'hAAAA_AAAA, 20'hA_AAAA, 16'hAAAA));
        send_req(make_req(CMD_APPEND, 32'h5555_5555, 20'h5_5555, 16'h5555));
        send_req(make_req(CMD_SEARCH, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hF0FF));
        send_req(make_req(CMD_SEARCH, 32'h0, 20'h0, 16'h0A00));
        send_req(make_req(CMD_SEARCH, 32'h5555_5555, 20'h5_5555, 16'h5555));
        send_req(make_req(CMD_SEARCH, 32'h1234_5678, 20'h9_ABCD, 16'hEF01));
        send_req(make_req(CMD_UNUSED, 32'h0, 20'h0, 16'h0));
        send_req(make_req(CMD_REMOVE, 32'h0, 20'h0, 16'h0));
        send_req(make_req(CMD_SEARCH, 32'h0, 20'h0, 16'h0));
        send_req(make_req(CMD_REMOVE, 32'h5555_5555, 20'h5_5555, 16'h5555));
        send_req(make_req(CMD_REMOVE, 32'hAAAA_AAAA, 20'hA_AAAA, 16'hAAAA));
        send_req(make_req(CMD_REMOVE, 32'hAAAA_AAAA, 20'hA_AAAA, 16'hAAAA));
        send_req(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hFFFF));
        send_req(make_req(CMD_REMOVE, 32'h0, 20'h0, 16'h0F00));
    endtask

    task automatic test_table_capacity();
        while (table_words.size() < TABLE_DEPTH) begin
            send_req(random_req(100));
        end
        send_req(make_req(CMD_APPEND, 32'h0BAD_0000, 20'h0_1234, 16'h9A00));
        send_req(make_req(CMD_APPEND, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hFFFF));
        send_req(make_req(CMD_UNUSED, 32'h0BAD_0000, 20'h0_1234, 16'h9A00));
        send_req(req_for_word(CMD_SEARCH, table_words[TABLE_DEPTH - 1]));
        send_req(make_req(CMD_SEARCH, 32'h0BAD_0000, 20'h0_1234, 16'h9A00));
        send_req(req_for_word(CMD_REMOVE, table_words[0]));
        send_req(make_req(CMD_APPEND, 32'h0BAD_0000, 20'h0_1234, 16'h9A00));
        send_req(req_for_word(CMD_REMOVE, table_words[TABLE_DEPTH - 1]));
        send_req(req_for_word(CMD_REMOVE, table_words[TABLE_DEPTH / 2]));
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int append_pct);
        gap_pct = idle_pct;
        repeat (n_items) send_req(random_req(append_pct));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct = 28;
        test_empty_table();
        test_basic_ops();
        test_table_capacity();
        test_random_traffic(500, 28, 40);
        test_random_traffic(500, 45, 55);
        test_random_traffic(500, 0, 30);

        start <= 1'b0;
        for (int n = 0; n < 2000 && pending_rsps.size() > 0; n++) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (pending_rsps.size() != 0) begin
            $error("%0d results never arrived", pending_rsps.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
